### rtl/hce_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the two-level calendar enqueue block.
// No dependencies; every other file but hce_ram imports this package.
package hce_pkg;

  // Calendar geometry and flow table size (both powers of two)
  localparam int SLOTS_PER_LEVEL = 8;
  localparam int FLOW_COUNT      = 1024;
  localparam int SLOT_BITS       = $clog2(SLOTS_PER_LEVEL);
  localparam int FLOW_BITS       = $clog2(FLOW_COUNT);

  // Field widths
  localparam int TAG_W      = 16;
  localparam int FLOW_W     = 10;
  localparam int ROUND_W    = 32;
  localparam int WEIGHT_W   = 8;
  localparam int BURST_W    = 16;
  localparam int STEP_W     = 3;
  localparam int VERDICT_W  = 2;
  localparam int TARGET_W   = 2;
  localparam int INDEX_W    = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived widths
  localparam int SLOTNUM_W = ROUND_W - SLOT_BITS;
  localparam int CMP_W     = (SLOT_BITS > STEP_W) ? SLOT_BITS : STEP_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_WEIGHT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN_SLOT = 2'd2;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] FLOW_WEIGHT_RST    = 8'd2;
  localparam logic [BURST_W-1:0]  BURST_LIMIT_RST    = 16'd100;
  localparam logic [STEP_W-1:0]   STEP_DOWN_SLOT_RST = 3'd7;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_QUEUED  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_HORIZON = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_BURST   = 2'd2;

  // Target queue codes
  localparam logic [TARGET_W-1:0] TARGET_BANK_A    = 2'd0;
  localparam logic [TARGET_W-1:0] TARGET_BANK_B    = 2'd1;
  localparam logic [TARGET_W-1:0] TARGET_LEVEL1    = 2'd2;
  localparam logic [TARGET_W-1:0] TARGET_STEP_DOWN = 2'd3;

  // Per-flow table entry
  typedef struct packed {
    logic               upper;
    logic [ROUND_W-1:0] finish;
  } flow_entry_t;

  localparam int ENTRY_W = $bits(flow_entry_t);

  // Configuration registers as seen by the placement logic
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [BURST_W-1:0]  burst;
    logic [STEP_W-1:0]   step;
  } cfg_regs_t;

  // Placement decision for one packet
  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [TARGET_W-1:0]  target;
    logic [INDEX_W-1:0]   slot;
    logic [ROUND_W-1:0]   finish;
    logic                 update;
    flow_entry_t          entry;
  } calc_res_t;

endpackage

### rtl/hce_in_if.sv
`timescale 1ns / 1ps
// Packet arrival channel: valid/ready plus tag, flow and current round.
// Depends on hce_pkg.
interface hce_in_if import hce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TAG_W-1:0]   packet_tag;
  logic [FLOW_W-1:0]  flow_number;
  logic [ROUND_W-1:0] now_round;

  modport source (output valid, packet_tag, flow_number, now_round, input ready);
  modport sink (input valid, packet_tag, flow_number, now_round, output ready);
endinterface

### rtl/hce_out_if.sv
`timescale 1ns / 1ps
// Placement result channel: valid/ready plus tag, verdict, target, index and round.
// Depends on hce_pkg.
interface hce_out_if import hce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TAG_W-1:0]     tag_out;
  logic [VERDICT_W-1:0] verdict;
  logic [TARGET_W-1:0]  target_queue;
  logic [INDEX_W-1:0]   slot_index;
  logic [ROUND_W-1:0]   finish_round;

  modport source (output valid, tag_out, verdict, target_queue, slot_index, finish_round,
                  input ready);
  modport sink (input valid, tag_out, verdict, target_queue, slot_index, finish_round,
                output ready);
endinterface

### rtl/hce_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready plus register index and data.
// Depends on hce_pkg.
interface hce_cfg_if import hce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/hce_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first-come, read returns the contents before this edge's write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/hce_calc.sv
`timescale 1ns / 1ps
// Departure round, drop checks and calendar placement for one packet.
// Depends on hce_pkg.
module hce_calc import hce_pkg::*; (
  input  logic [ROUND_W-1:0] now_round,
  input  flow_entry_t        entry,
  input  cfg_regs_t          regs,
  output calc_res_t          res
);

  logic [ROUND_W-1:0]   start;
  logic [ROUND_W:0]     dep;
  logic [SLOTNUM_W-1:0] dslot;
  logic [SLOTNUM_W-1:0] nslot;
  logic [SLOTNUM_W-1:0] slot_gap;
  logic [ROUND_W-1:0]   lead;
  logic [CMP_W-1:0]     ring_pos;
  logic [CMP_W-1:0]     step_pos;

  // Departure = max(now, last) + weight, one bit wider to catch overflow
  always_comb begin
    start    = (now_round > entry.finish) ? now_round : entry.finish;
    dep      = {1'b0, start} + (ROUND_W + 1)'(regs.weight);
    dslot    = dep[ROUND_W-1:SLOT_BITS];
    nslot    = now_round[ROUND_W-1:SLOT_BITS];
    slot_gap = dslot - nslot;
    lead     = dep[ROUND_W-1:0] - now_round;
    ring_pos = CMP_W'(dslot[SLOT_BITS-1:0]);
    step_pos = CMP_W'(regs.step);
  end

  // Drop checks in priority order, then placement
  always_comb begin
    res.verdict = VERDICT_QUEUED;
    res.target  = TARGET_BANK_A;
    res.slot    = '0;
    res.finish  = dep[ROUND_W-1:0];
    res.update  = 1'b0;
    res.entry   = entry;
    if (dep[ROUND_W]) begin
      res.verdict = VERDICT_HORIZON;
      res.finish  = '1;
    end else if (slot_gap >= SLOTNUM_W'(SLOTS_PER_LEVEL)) begin
      res.verdict = VERDICT_HORIZON;
    end else if (lead >= ROUND_W'(regs.burst)) begin
      res.verdict = VERDICT_BURST;
    end else begin
      res.update       = 1'b1;
      res.entry.finish = dep[ROUND_W-1:0];
      if (slot_gap > SLOTNUM_W'(1) || entry.upper) begin
        if (ring_pos == step_pos) begin
          res.entry.upper = 1'b0;
          res.target      = TARGET_STEP_DOWN;
          res.slot        = INDEX_W'(dep[SLOT_BITS-1:0]);
        end else begin
          res.entry.upper = 1'b1;
          res.target      = TARGET_LEVEL1;
          res.slot        = INDEX_W'(dslot[SLOT_BITS-1:0]);
        end
      end else begin
        res.entry.upper = 1'b0;
        res.target      = dslot[0] ? TARGET_BANK_B : TARGET_BANK_A;
        res.slot        = INDEX_W'(dep[SLOT_BITS-1:0]);
      end
    end
  end

endmodule

### rtl/hierarchical_calendar_enqueue_top.sv
`timescale 1ns / 1ps
// Enqueue side of a two-level calendar scheduler: one packet in, one placement out.
// Depends on hce_pkg, hce_in_if, hce_out_if, hce_cfg_if, hce_ram and hce_calc.
//
// The block takes one packet per clock cycle unless the result side stalls; its
// placement goes through the table read, then the result register. That rate is set by
// the per-flow read-modify-write: the flow table is a RAM with registered read, and
// the entry written by one packet is forwarded to the packet right behind it when
// both name the same flow. After reset the table is cleared one entry per cycle, and
// no packet is taken until the clear is done; configuration writes are taken
// throughout. Configuration should only change while no packet is in flight.
module hierarchical_calendar_enqueue_top import hce_pkg::*; (
  input logic        clk,
  input logic        rst,
  hce_in_if.sink     pkt_in,
  hce_out_if.source  pkt_out,
  hce_cfg_if.sink    cfg
);

  cfg_regs_t              regs;

  logic                   clear_busy;
  logic [FLOW_BITS-1:0]   clear_addr;

  logic                   in_ready;
  logic                   in_fire;
  logic [FLOW_BITS-1:0]   in_flow;

  logic                   s1_valid;
  logic                   s1_adv;
  logic [TAG_W-1:0]       s1_tag;
  logic [FLOW_BITS-1:0]   s1_flow;
  logic [ROUND_W-1:0]     s1_now;

  logic                   fwd_valid;
  logic [FLOW_BITS-1:0]   fwd_flow;
  flow_entry_t            fwd_entry;

  logic                   tbl_we;
  logic [FLOW_BITS-1:0]   tbl_waddr;
  logic [ENTRY_W-1:0]     tbl_wdata;
  logic [ENTRY_W-1:0]     tbl_rdata;
  flow_entry_t            cur_entry;
  calc_res_t              res;

  logic                   out_valid;
  logic [TAG_W-1:0]       out_tag;
  logic [VERDICT_W-1:0]   out_verdict;
  logic [TARGET_W-1:0]    out_target;
  logic [INDEX_W-1:0]     out_slot;
  logic [ROUND_W-1:0]     out_finish;

  // Configuration writes; indexes beyond the list are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.weight <= FLOW_WEIGHT_RST;
      regs.burst  <= BURST_LIMIT_RST;
      regs.step   <= STEP_DOWN_SLOT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FLOW_WEIGHT:    regs.weight <= cfg.data[WEIGHT_W-1:0];
        REG_BURST_LIMIT:    regs.burst  <= cfg.data[BURST_W-1:0];
        REG_STEP_DOWN_SLOT: regs.step   <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sweep the flow table to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      clear_addr <= clear_addr + FLOW_BITS'(1);
      if (clear_addr == FLOW_BITS'(FLOW_COUNT - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  // Input handshake: take a packet whenever the table clear is done and stage 1 is free or moving on
  assign s1_adv       = s1_valid && (!out_valid || pkt_out.ready);
  assign in_ready     = !clear_busy && (!s1_valid || s1_adv);
  assign in_fire      = pkt_in.valid && in_ready;
  assign in_flow      = FLOW_BITS'(pkt_in.flow_number);
  assign pkt_in.ready = in_ready;

  // Per-flow table
  assign tbl_we    = clear_busy || (s1_adv && res.update);
  assign tbl_waddr = clear_busy ? clear_addr : s1_flow;
  assign tbl_wdata = clear_busy ? '0 : res.entry;

  hce_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FLOW_COUNT)
  ) u_flow_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (in_fire),
    .raddr (in_flow),
    .rdata (tbl_rdata)
  );

  // Stage 1 holds the packet while its table read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tag  <= pkt_in.packet_tag;
      s1_flow <= in_flow;
      s1_now  <= pkt_in.now_round;
    end
  end

  // Remember the last table write to cover a read issued on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_adv && res.update) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.update) begin
      fwd_flow  <= s1_flow;
      fwd_entry <= res.entry;
    end
  end

  assign cur_entry = (fwd_valid && fwd_flow == s1_flow) ? fwd_entry : flow_entry_t'(tbl_rdata);

  hce_calc u_calc (
    .now_round (s1_now),
    .entry     (cur_entry),
    .regs      (regs),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (pkt_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tag     <= s1_tag;
      out_verdict <= res.verdict;
      out_target  <= res.target;
      out_slot    <= res.slot;
      out_finish  <= res.finish;
    end
  end

  assign pkt_out.valid        = out_valid;
  assign pkt_out.tag_out      = out_tag;
  assign pkt_out.verdict      = out_verdict;
  assign pkt_out.target_queue = out_target;
  assign pkt_out.slot_index   = out_slot;
  assign pkt_out.finish_round = out_finish;

  // Table is written by packets only when they are queued
  assert property (@(posedge clk) disable iff (rst)
    tbl_we && !clear_busy |-> s1_adv && res.verdict == VERDICT_QUEUED)
    else $error("flow table written by a dropped or stalled packet");

  // A queued packet never departs before the current round
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && res.verdict == VERDICT_QUEUED |-> res.finish >= s1_now)
    else $error("queued departure earlier than current round");

  // Dropped packets report target and index zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_verdict != VERDICT_QUEUED |-> out_target == TARGET_BANK_A && out_slot == '0)
    else $error("dropped packet carries a placement");

  // No packet enters while the table is being cleared
  assert property (@(posedge clk) disable iff (rst)
    clear_busy |=> !$past(in_fire) && !s1_valid)
    else $error("packet taken during table clear");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the two-level calendar enqueue block.
// Depends on hce_pkg, hce_in_if, hce_out_if, hce_cfg_if and hierarchical_calendar_enqueue_top.
module tb_top;
  import hce_pkg::*;

  localparam int                   WATCHDOG_CYCLES = 300000;
  localparam int                   RX_HOLD_CYCLES  = 64;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 2'd3;

  // One expected placement as it leaves the block
  typedef struct packed {
    logic [TAG_W-1:0]     tag;
    logic [VERDICT_W-1:0] verdict;
    logic [TARGET_W-1:0]  target;
    logic [INDEX_W-1:0]   slot;
    logic [ROUND_W-1:0]   finish;
  } placement_t;

  logic clk = 1'b0;
  logic rst;

  hce_in_if  pkt_in ();
  hce_out_if pkt_out ();
  hce_cfg_if cfg ();

  hierarchical_calendar_enqueue_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pkt_in),
    .pkt_out (pkt_out),
    .cfg     (cfg)
  );

  // Shadow copy of the registers and the per-flow table
  logic [WEIGHT_W-1:0] weight_reg;
  logic [BURST_W-1:0]  burst_reg;
  logic [STEP_W-1:0]   step_reg;
  logic [ROUND_W-1:0]  flow_finish [FLOW_COUNT];
  logic                flow_upper  [FLOW_COUNT];

  placement_t pending_placements [$];
  placement_t seen_want;

  int  mismatches;
  int  placements_checked;
  int  cnt_queued, cnt_horizon, cnt_burst;
  int  cnt_bank, cnt_level1, cnt_step_down;
  bit  no_idle;
  int  hold_asked, hold_given;
  int  cycle_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the placement of one packet and update the flow table
  function automatic placement_t place_packet(input logic [TAG_W-1:0] tag,
                                              input logic [FLOW_W-1:0] flow,
                                              input logic [ROUND_W-1:0] now);
    placement_t             p;
    int                     entry;
    logic [ROUND_W-1:0]     prior;
    logic [ROUND_W:0]       depart;
    logic [ROUND_W:0]       ahead;
    logic [SLOTNUM_W-1:0]   dep_slot;
    logic [SLOTNUM_W-1:0]   now_slot;
    logic [SLOTNUM_W-1:0]   slot_gap;
    entry    = flow % FLOW_COUNT;
    prior    = flow_finish[entry];
    depart   = {1'b0, (now > prior) ? now : prior} + weight_reg;
    p.tag     = tag;
    p.verdict = VERDICT_QUEUED;
    p.target  = TARGET_BANK_A;
    p.slot    = '0;
    p.finish  = depart[ROUND_W-1:0];
    dep_slot = depart[ROUND_W-1:SLOT_BITS];
    now_slot = now[ROUND_W-1:SLOT_BITS];
    slot_gap = dep_slot - now_slot;
    ahead    = depart - {1'b0, now};
    if (depart[ROUND_W]) begin
      // departure does not fit in a round number
      p.verdict = VERDICT_HORIZON;
      p.finish  = '1;
    end else if (slot_gap >= SLOTS_PER_LEVEL) begin
      p.verdict = VERDICT_HORIZON;
    end else if (ahead >= burst_reg) begin
      p.verdict = VERDICT_BURST;
    end else begin
      flow_finish[entry] = depart[ROUND_W-1:0];
      // slot count is a power of two, so modulo is a bit select
      if (slot_gap > 1 || flow_upper[entry]) begin
        if (dep_slot[SLOT_BITS-1:0] == step_reg) begin
          flow_upper[entry] = 1'b0;
          p.target = TARGET_STEP_DOWN;
          p.slot   = depart[SLOT_BITS-1:0];
        end else begin
          flow_upper[entry] = 1'b1;
          p.target = TARGET_LEVEL1;
          p.slot   = dep_slot[SLOT_BITS-1:0];
        end
      end else begin
        flow_upper[entry] = 1'b0;
        p.target = dep_slot[0] ? TARGET_BANK_B : TARGET_BANK_A;
        p.slot   = depart[SLOT_BITS-1:0];
      end
    end
    return p;
  endfunction

  // Offer one packet, wait for its transfer, then queue its placement
  task automatic send_packet(input logic [TAG_W-1:0] tag, input logic [FLOW_W-1:0] flow,
                             input logic [ROUND_W-1:0] now);
    placement_t want;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      pkt_in.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    pkt_in.valid       <= 1'b1;
    pkt_in.packet_tag  <= tag;
    pkt_in.flow_number <= flow;
    pkt_in.now_round   <= now;
    do @(posedge clk); while (pkt_in.ready !== 1'b1);
    want = place_packet(tag, flow, now);
    pending_placements = {pending_placements, want};
    case (want.verdict)
      VERDICT_QUEUED:  cnt_queued++;
      VERDICT_HORIZON: cnt_horizon++;
      default:         cnt_burst++;
    endcase
    if (want.verdict == VERDICT_QUEUED) begin
      case (want.target)
        TARGET_LEVEL1:    cnt_level1++;
        TARGET_STEP_DOWN: cnt_step_down++;
        default:          cnt_bank++;
      endcase
    end
  endtask

  // Write one register; the shadow copy follows at the transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    case (idx)
      REG_FLOW_WEIGHT:    weight_reg = value[WEIGHT_W-1:0];
      REG_BURST_LIMIT:    burst_reg  = value[BURST_W-1:0];
      REG_STEP_DOWN_SLOT: step_reg   = value[STEP_W-1:0];
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering packets until every placement is back and the pipe is empty
  task automatic drain_results();
    pkt_in.valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reconfigure while idle; unused upper data bits carry noise
  task automatic apply_setting(input logic [WEIGHT_W-1:0] w, input logic [BURST_W-1:0] b,
                               input logic [STEP_W-1:0] s);
    logic [CFG_DATA_W-1:0] d;
    drain_results();
    d = CFG_DATA_W'($urandom);
    d[WEIGHT_W-1:0] = w;
    write_reg(REG_FLOW_WEIGHT, d);
    write_reg(REG_BURST_LIMIT, b);
    d = CFG_DATA_W'($urandom);
    d[STEP_W-1:0] = s;
    write_reg(REG_STEP_DOWN_SLOT, d);
  endtask

  // Mostly a few busy flows near an advancing round, plus noise,
  // near-overflow rounds and late rounds
  task automatic run_random(input int count, input int hot_span,
                            input logic [ROUND_W-1:0] start_round);
    logic [FLOW_W-1:0]  hot [8];
    logic [ROUND_W-1:0] base;
    logic [FLOW_W-1:0]  flow;
    logic [ROUND_W-1:0] now;
    int                 pick;
    base = start_round;
    foreach (hot[i]) hot[i] = FLOW_W'($urandom_range(0, FLOW_COUNT - 1));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      flow = hot[$urandom_range(0, hot_span - 1)];
      now  = base + $urandom_range(0, 7);
      if (pick >= 93) begin
        now = base - $urandom_range(1, 64);
      end else if (pick >= 85) begin
        flow = FLOW_W'($urandom_range(0, FLOW_COUNT - 1));
        now  = 32'hFFFF_FFFF - $urandom_range(0, 300);
      end else if (pick >= 75) begin
        flow = FLOW_W'($urandom_range(0, FLOW_COUNT - 1));
        now  = $urandom;
      end
      send_packet(TAG_W'($urandom_range(0, 65535)), flow, now);
      base = base + $urandom_range(0, 4);
    end
  endtask

  // Reset values, field extremes, round overflow and back-to-back same flow
  task automatic test_defaults();
    send_packet(16'h0000, 10'd0, 32'd0);
    send_packet(16'hFFFF, 10'd1023, 32'hFFFF_FFFD);
    send_packet(16'h1234, 10'd1023, 32'd0);
    send_packet(16'h8001, 10'd5, 32'hFFFF_FFFF);
    repeat (4) send_packet(TAG_W'($urandom_range(0, 65535)), 10'd3, 32'd10);
  endtask

  // Walk one flow through level 0, level 1, step-down and the horizon
  task automatic test_level_walk();
    apply_setting(8'd8, 16'd100, 3'd7);
    repeat (8) send_packet(TAG_W'($urandom_range(0, 65535)), 10'd7, 32'd0);
    // flag still set although the departure is close
    send_packet(TAG_W'($urandom_range(0, 65535)), 10'd8, 32'd0);
    send_packet(TAG_W'($urandom_range(0, 65535)), 10'd8, 32'd0);
    send_packet(TAG_W'($urandom_range(0, 65535)), 10'd8, 32'd16);
  endtask

  // Burst limit hit, zero burst limit, zero weight and an unused register index
  task automatic test_burst_and_weight();
    apply_setting(8'd8, 16'd20, 3'd7);
    repeat (3) send_packet(TAG_W'($urandom_range(0, 65535)), 10'd9, 32'd0);
    apply_setting(8'd8, 16'd0, 3'd7);
    send_packet(TAG_W'($urandom_range(0, 65535)), 10'd10, 32'd0);
    apply_setting(8'd0, 16'd100, 3'd4);
    write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 65535)));
    repeat (2) send_packet(TAG_W'($urandom_range(0, 65535)), 10'd11, 32'd100);
  endtask

  // Hold the result side for a long stretch while packets keep coming
  task automatic test_backpressure();
    apply_setting(FLOW_WEIGHT_RST, BURST_LIMIT_RST, STEP_DOWN_SLOT_RST);
    no_idle = 1'b1;
    hold_asked++;
    run_random(20, 2, $urandom_range(0, 1000));
    no_idle = 1'b0;
  endtask

  // Random traffic under several settings, extremes among them
  task automatic test_random_phases();
    apply_setting(8'd1, 16'hFFFF, 3'd0);
    run_random(60, 8, $urandom_range(0, 1000));
    apply_setting(8'd255, 16'd1, 3'd7);
    run_random(20, 8, $urandom);
    apply_setting(FLOW_WEIGHT_RST, BURST_LIMIT_RST, STEP_DOWN_SLOT_RST);
    run_random(60, 4, $urandom);
    apply_setting(8'd8, 16'd300, 3'd3);
    run_random(70, 4, $urandom_range(0, 100000));
    apply_setting(8'd0, 16'd0, 3'd5);
    run_random(20, 8, $urandom);
    apply_setting(WEIGHT_W'($urandom_range(1, 40)), BURST_W'($urandom_range(1, 200)),
                  STEP_W'($urandom_range(0, 7)));
    run_random(60, 8, $urandom);
    apply_setting(WEIGHT_W'($urandom_range(4, 16)), BURST_W'($urandom_range(1, 65535)),
                  STEP_W'($urandom_range(0, 7)));
    run_random(60, 4, $urandom);
  endtask

  // Full rate on both sides, few flows so that back-to-back repeats are common
  task automatic test_streaming();
    apply_setting(8'd5, 16'd70, STEP_W'($urandom_range(0, 7)));
    no_idle = 1'b1;
    run_random(60, 2, $urandom);
  endtask

  // Result side: ready in random bursts, long holds on request
  initial begin
    pkt_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        pkt_out.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        pkt_out.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(posedge clk);
      end else begin
        pkt_out.ready <= 1'b1;
      end
    end
  end

  // Compare every result transfer with the oldest expected placement
  always @(posedge clk) begin
    if (!rst && pkt_out.valid === 1'b1 && pkt_out.ready === 1'b1) begin
      if (pending_placements.size() == 0) begin
        $error("unexpected placement: tag_out %0h", pkt_out.tag_out);
        mismatches++;
      end else begin
        seen_want = pending_placements.pop_front();
        placements_checked++;
        if (pkt_out.tag_out !== seen_want.tag) begin
          $error("tag_out: expected %0h, got %0h", seen_want.tag, pkt_out.tag_out);
          mismatches++;
        end
        if (pkt_out.verdict !== seen_want.verdict) begin
          $error("verdict: expected %0d, got %0d", seen_want.verdict, pkt_out.verdict);
          mismatches++;
        end
        if (pkt_out.target_queue !== seen_want.target) begin
          $error("target_queue: expected %0d, got %0d", seen_want.target,
                 pkt_out.target_queue);
          mismatches++;
        end
        if (pkt_out.slot_index !== seen_want.slot) begin
          $error("slot_index: expected %0d, got %0d", seen_want.slot, pkt_out.slot_index);
          mismatches++;
        end
        if (pkt_out.finish_round !== seen_want.finish) begin
          $error("finish_round: expected %0h, got %0h", seen_want.finish,
                 pkt_out.finish_round);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout with %0d placements outstanding", pending_placements.size());
    $display("hierarchical_calendar_enqueue_top test failed");
    $finish;
  end

  // Reset, then run the tests in turn
  initial begin
    rst                <= 1'b1;
    pkt_in.valid       <= 1'b0;
    pkt_in.packet_tag  <= '0;
    pkt_in.flow_number <= '0;
    pkt_in.now_round   <= '0;
    cfg.valid          <= 1'b0;
    cfg.index          <= '0;
    cfg.data           <= '0;
    weight_reg = FLOW_WEIGHT_RST;
    burst_reg  = BURST_LIMIT_RST;
    step_reg   = STEP_DOWN_SLOT_RST;
    foreach (flow_finish[i]) flow_finish[i] = '0;
    foreach (flow_upper[i]) flow_upper[i] = 1'b0;
    mismatches = 0;
    placements_checked = 0;
    cnt_queued = 0;
    cnt_horizon = 0;
    cnt_burst = 0;
    cnt_bank = 0;
    cnt_level1 = 0;
    cnt_step_down = 0;
    no_idle = 1'b0;
    hold_asked = 0;
    hold_given = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_defaults();
    test_level_walk();
    test_burst_and_weight();
    test_backpressure();
    test_random_phases();
    test_streaming();
    drain_results();
    repeat (8) @(posedge clk);

    $display("%0d placements checked: %0d queued, %0d beyond horizon, %0d over burst",
             placements_checked, cnt_queued, cnt_horizon, cnt_burst);
    $display("queued to level 0: %0d, level 1: %0d, step-down: %0d",
             cnt_bank, cnt_level1, cnt_step_down);
    if (mismatches == 0) begin
      $display("hierarchical_calendar_enqueue_top test passed");
    end else begin
      $display("hierarchical_calendar_enqueue_top test failed");
    end
    $finish;
  end

endmodule
